@@ rtl/assert_macros.svh @@
// Assertion macros shared by the midpoint ellipse stepper modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define MES_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define MES_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/mes_pkg.sv @@
// Shared constants, operation codes and control types of the ellipse stepper.
package mes_pkg;

    localparam int CEN_W            = 10;
    localparam int RADIUS_BITS_DEF  = 10;
    localparam int COORD_BITS_DEF   = 12;

    localparam int OP_W = 4;
    typedef logic [OP_W-1:0] t_op;

    localparam t_op OP_NONE   = 4'd0;
    localparam t_op OP_LOAD   = 4'd1;
    localparam t_op OP_SQX    = 4'd2;
    localparam t_op OP_SQY    = 4'd3;
    localparam t_op OP_MT     = 4'd4;
    localparam t_op OP_INIT1  = 4'd5;
    localparam t_op OP_MA     = 4'd6;
    localparam t_op OP_MB     = 4'd7;
    localparam t_op OP_MC     = 4'd8;
    localparam t_op OP_MD     = 4'd9;
    localparam t_op OP_ME     = 4'd10;
    localparam t_op OP_MF     = 4'd11;
    localparam t_op OP_R2INIT = 4'd12;
    localparam t_op OP_STEP1  = 4'd13;
    localparam t_op OP_STEP2  = 4'd14;
    localparam t_op OP_NOACT  = 4'd15;

    typedef struct packed {
        t_op  op;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic active;
        logic region_two;
        logic px_lt_py;
        logic out_free;
    } t_sts;

endpackage

@@ rtl/mes_if.sv @@
// Valid/ready channel interfaces for the input items and the result points.
interface mes_in_if
    import mes_pkg::*;
#(
    parameter int RADIUS_BITS = RADIUS_BITS_DEF
) ();
    logic                   valid;
    logic                   ready;
    logic                   func;
    logic [CEN_W-1:0]       center_x;
    logic [CEN_W-1:0]       center_y;
    logic [RADIUS_BITS-1:0] radius_x;
    logic [RADIUS_BITS-1:0] radius_y;

    modport source (output valid, func, center_x, center_y, radius_x, radius_y,
                    input ready);
    modport sink   (input valid, func, center_x, center_y, radius_x, radius_y,
                    output ready);
endinterface

interface mes_out_if
    import mes_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) ();
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] x_right;
    logic signed [COORD_BITS-1:0] x_left;
    logic signed [COORD_BITS-1:0] y_upper;
    logic signed [COORD_BITS-1:0] y_lower;
    logic                         last_point;
    logic                         status;

    modport source (output valid, x_right, x_left, y_upper, y_lower, last_point, status,
                    input ready);
    modport sink   (input valid, x_right, x_left, y_upper, y_lower, last_point, status,
                    output ready);
endinterface

@@ rtl/mes_ctrl.sv @@
// Sequencing state machine of the ellipse stepper.
`include "assert_macros.svh"

module mes_ctrl
    import mes_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  logic i_func,
    input  t_sts i_sts,
    output logic o_ready,
    output t_cmd o_cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SQX    = 4'd1;
    localparam logic [3:0] S_SQY    = 4'd2;
    localparam logic [3:0] S_MT     = 4'd3;
    localparam logic [3:0] S_INIT1  = 4'd4;
    localparam logic [3:0] S_MA     = 4'd5;
    localparam logic [3:0] S_MB     = 4'd6;
    localparam logic [3:0] S_MC     = 4'd7;
    localparam logic [3:0] S_MD     = 4'd8;
    localparam logic [3:0] S_ME     = 4'd9;
    localparam logic [3:0] S_MF     = 4'd10;
    localparam logic [3:0] S_R2INIT = 4'd11;
    localparam logic [3:0] S_STEP1  = 4'd12;
    localparam logic [3:0] S_STEP2  = 4'd13;
    localparam logic [3:0] S_NOACT  = 4'd14;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       w_accept;

    assign o_ready  = (r_state == S_IDLE);
    assign w_accept = i_valid && o_ready;

    always_comb begin
        n_state     = r_state;
        o_cmd.op    = OP_NONE;
        o_cmd.emit  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (!i_func) begin
                        o_cmd.op = OP_LOAD;
                        n_state  = S_SQX;
                    end else if (!i_sts.active) begin
                        n_state = S_NOACT;
                    end else if (i_sts.region_two) begin
                        n_state = S_STEP2;
                    end else if (i_sts.px_lt_py) begin
                        n_state = S_STEP1;
                    end else begin
                        n_state = S_MA;
                    end
                end
            end
            S_SQX: begin
                o_cmd.op = OP_SQX;
                n_state  = S_SQY;
            end
            S_SQY: begin
                o_cmd.op = OP_SQY;
                n_state  = S_MT;
            end
            S_MT: begin
                o_cmd.op = OP_MT;
                n_state  = S_INIT1;
            end
            S_MA: begin
                o_cmd.op = OP_MA;
                n_state  = S_MB;
            end
            S_MB: begin
                o_cmd.op = OP_MB;
                n_state  = S_MC;
            end
            S_MC: begin
                o_cmd.op = OP_MC;
                n_state  = S_MD;
            end
            S_MD: begin
                o_cmd.op = OP_MD;
                n_state  = S_ME;
            end
            S_ME: begin
                o_cmd.op = OP_ME;
                n_state  = S_MF;
            end
            S_MF: begin
                o_cmd.op = OP_MF;
                n_state  = S_R2INIT;
            end
            S_R2INIT: begin
                o_cmd.op = OP_R2INIT;
                n_state  = S_STEP2;
            end
            // The point-producing states hold until the output register can take a beat.
            S_INIT1: begin
                if (i_sts.out_free) begin
                    o_cmd.op   = OP_INIT1;
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_STEP1: begin
                if (i_sts.out_free) begin
                    o_cmd.op   = OP_STEP1;
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_STEP2: begin
                if (i_sts.out_free) begin
                    o_cmd.op   = OP_STEP2;
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_NOACT: begin
                if (i_sts.out_free) begin
                    o_cmd.op   = OP_NOACT;
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `MES_ASSERT_NOW(a_emit_needs_room, o_cmd.emit, i_sts.out_free, "point emitted into a full output register")
    `MES_ASSERT_NEXT(a_idle_next, w_accept && i_func && !i_sts.active, r_state == S_NOACT, "next beat without ellipse did not report idle")
    `MES_ASSERT_NEXT(a_switch_region, w_accept && i_func && i_sts.active && !i_sts.region_two && !i_sts.px_lt_py, r_state == S_MA, "region switch did not start the decision setup")

endmodule

@@ rtl/mes_dp.sv @@
// Datapath of the ellipse stepper: shared multiplier, decision terms and output register.
`include "assert_macros.svh"

module mes_dp
    import mes_pkg::*;
#(
    parameter int RADIUS_BITS = RADIUS_BITS_DEF,
    parameter int COORD_BITS  = COORD_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [CEN_W-1:0]       i_center_x,
    input  logic [CEN_W-1:0]       i_center_y,
    input  logic [RADIUS_BITS-1:0] i_radius_x,
    input  logic [RADIUS_BITS-1:0] i_radius_y,
    input  t_cmd                   i_cmd,
    output t_sts                   o_sts,
    mes_out_if.source              o_out
);

    localparam int OFFX_W = RADIUS_BITS + 1;
    localparam int OFFY_W = RADIUS_BITS;
    localparam int SQ_W   = 2 * RADIUS_BITS;
    localparam int MB_W   = RADIUS_BITS + 2;
    localparam int MA_W   = 3 * RADIUS_BITS + 2;
    localparam int PR_W   = MA_W + MB_W;
    localparam int TERM_W = (3 * RADIUS_BITS + 3 > 64) ? 64 : 3 * RADIUS_BITS + 3;
    localparam int DEC_W  = (4 * RADIUS_BITS + 8 > 64) ? 64 : 4 * RADIUS_BITS + 8;
    localparam int EXT_W  = COORD_BITS + OFFX_W + CEN_W;

    logic [CEN_W-1:0]       r_cen_x, r_cen_y, n_cen_x, n_cen_y;
    logic [RADIUS_BITS-1:0] r_rx, r_ry, n_rx, n_ry;
    logic [SQ_W-1:0]        r_rad_x_sq, r_rad_y_sq, n_rad_x_sq, n_rad_y_sq;
    logic [OFFX_W-1:0]      r_off_x, n_off_x;
    logic [OFFY_W-1:0]      r_off_y, n_off_y;
    logic [TERM_W-1:0]      r_px, r_py, n_px, n_py;
    logic [DEC_W-1:0]       r_dec, n_dec;
    logic [PR_W-1:0]        r_prod, n_prod;
    logic [DEC_W-1:0]       r_acc, n_acc;
    logic                   r_region_two, n_region_two;
    logic                   r_active, n_active;
    logic                   r_out_valid, n_out_valid;
    logic signed [COORD_BITS-1:0] r_x_right, r_x_left, r_y_upper, r_y_lower;
    logic signed [COORD_BITS-1:0] n_x_right, n_x_left, n_y_upper, n_y_lower;
    logic                   r_last, n_last;
    logic                   r_status, n_status;

    logic [MB_W-1:0]   w_hx;
    logic [OFFY_W-1:0] w_ym;
    logic [MA_W-1:0]   w_mul_a;
    logic [MB_W-1:0]   w_mul_b;
    logic [PR_W-1:0]   w_prod;
    logic [TERM_W-1:0] w_px_inc, w_py_dec;
    logic [DEC_W-1:0]  e_rxsq, e_rysq, e_prod, e_px_inc, e_py_dec;
    logic [DEC_W-1:0]  w_q1, w_q2, w_q, w_t, w_tn, w_round;

    // Half-step terms for the region two setup: 2x+1 and y-1.
    assign w_hx = {r_off_x, 1'b1};
    assign w_ym = OFFY_W'(r_off_y - 1'b1);

    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (i_cmd.op)
            OP_SQX: begin
                w_mul_a = MA_W'(r_rx);
                w_mul_b = MB_W'(r_rx);
            end
            OP_SQY: begin
                w_mul_a = MA_W'(r_ry);
                w_mul_b = MB_W'(r_ry);
            end
            OP_MT, OP_ME: begin
                w_mul_a = MA_W'(r_rad_x_sq);
                w_mul_b = MB_W'(r_ry);
            end
            OP_MA: begin
                w_mul_a = MA_W'(r_rad_y_sq);
                w_mul_b = w_hx;
            end
            OP_MB: begin
                w_mul_a = r_prod[MA_W-1:0];
                w_mul_b = w_hx;
            end
            OP_MC: begin
                w_mul_a = MA_W'(r_rad_x_sq);
                w_mul_b = MB_W'(w_ym);
            end
            OP_MD: begin
                w_mul_a = r_prod[MA_W-1:0];
                w_mul_b = MB_W'(w_ym);
            end
            OP_MF: begin
                w_mul_a = r_prod[MA_W-1:0];
                w_mul_b = MB_W'(r_ry);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    assign w_px_inc = r_px + (TERM_W'(r_rad_y_sq) << 1);
    assign w_py_dec = r_py - (TERM_W'(r_rad_x_sq) << 1);
    assign e_rxsq   = DEC_W'(r_rad_x_sq);
    assign e_rysq   = DEC_W'(r_rad_y_sq);
    assign e_prod   = DEC_W'(r_prod);
    assign e_px_inc = DEC_W'(w_px_inc);
    assign e_py_dec = DEC_W'(w_py_dec);

    // Initial decisions in quarter units, then add one half and truncate toward zero.
    assign w_q1    = (e_rysq << 2) - (e_prod << 2) + e_rxsq;
    assign w_q2    = r_acc - (e_prod << 2);
    assign w_q     = (i_cmd.op == OP_INIT1) ? w_q1 : w_q2;
    assign w_t     = w_q + DEC_W'(2);
    assign w_tn    = -w_t;
    assign w_round = w_t[DEC_W-1] ? -(w_tn >> 2) : (w_t >> 2);

    always_comb begin
        n_cen_x      = r_cen_x;
        n_cen_y      = r_cen_y;
        n_rx         = r_rx;
        n_ry         = r_ry;
        n_rad_x_sq   = r_rad_x_sq;
        n_rad_y_sq   = r_rad_y_sq;
        n_off_x      = r_off_x;
        n_off_y      = r_off_y;
        n_px         = r_px;
        n_py         = r_py;
        n_dec        = r_dec;
        n_prod       = r_prod;
        n_acc        = r_acc;
        n_region_two = r_region_two;
        n_active     = r_active;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_x_right    = r_x_right;
        n_x_left     = r_x_left;
        n_y_upper    = r_y_upper;
        n_y_lower    = r_y_lower;
        n_last       = r_last;
        n_status     = r_status;
        case (i_cmd.op)
            OP_LOAD: begin
                n_cen_x      = i_center_x;
                n_cen_y      = i_center_y;
                n_rx         = i_radius_x;
                n_ry         = i_radius_y;
                n_off_x      = '0;
                n_off_y      = i_radius_y;
                n_px         = '0;
                n_region_two = 1'b0;
            end
            OP_SQX: begin
                n_rad_x_sq = w_prod[SQ_W-1:0];
            end
            OP_SQY: begin
                n_rad_y_sq = w_prod[SQ_W-1:0];
            end
            OP_MT, OP_MA, OP_MB, OP_MD, OP_MF: begin
                n_prod = w_prod;
            end
            OP_MC: begin
                n_prod = w_prod;
                n_acc  = e_prod;
            end
            OP_ME: begin
                n_prod = w_prod;
                n_acc  = r_acc + (e_prod << 2);
            end
            OP_INIT1: begin
                n_py  = TERM_W'(r_prod) << 1;
                n_dec = w_round;
            end
            OP_R2INIT: begin
                n_dec        = w_round;
                n_region_two = 1'b1;
            end
            OP_STEP1: begin
                n_off_x = OFFX_W'(r_off_x + 1'b1);
                n_px    = w_px_inc;
                if (r_dec[DEC_W-1]) begin
                    n_dec = r_dec + e_rysq + e_px_inc;
                end else begin
                    n_off_y = OFFY_W'(r_off_y - 1'b1);
                    n_py    = w_py_dec;
                    n_dec   = r_dec + e_rysq + e_px_inc - e_py_dec;
                end
            end
            OP_STEP2: begin
                n_off_y = OFFY_W'(r_off_y - 1'b1);
                n_py    = w_py_dec;
                if (!r_dec[DEC_W-1] && (r_dec != '0)) begin
                    n_dec = r_dec + e_rxsq - e_py_dec;
                end else begin
                    n_off_x = OFFX_W'(r_off_x + 1'b1);
                    n_px    = w_px_inc;
                    n_dec   = r_dec + e_rxsq - e_py_dec + e_px_inc;
                end
            end
            default: begin
                n_prod = r_prod;
            end
        endcase
        if (i_cmd.emit) begin
            n_out_valid = 1'b1;
            if (i_cmd.op == OP_NOACT) begin
                n_x_right = '0;
                n_x_left  = '0;
                n_y_upper = '0;
                n_y_lower = '0;
                n_last    = 1'b0;
                n_status  = 1'b1;
            end else begin
                n_x_right = COORD_BITS'(EXT_W'(r_cen_x) + EXT_W'(n_off_x));
                n_x_left  = COORD_BITS'(EXT_W'(r_cen_x) - EXT_W'(n_off_x));
                n_y_upper = COORD_BITS'(EXT_W'(r_cen_y) + EXT_W'(n_off_y));
                n_y_lower = COORD_BITS'(EXT_W'(r_cen_y) - EXT_W'(n_off_y));
                n_last    = (n_off_y == '0);
                n_status  = 1'b0;
                // The point with y offset zero closes the ellipse.
                n_active  = (n_off_y != '0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region_two <= 1'b0;
            r_active     <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_region_two <= n_region_two;
            r_active     <= n_active;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cen_x    <= n_cen_x;
        r_cen_y    <= n_cen_y;
        r_rx       <= n_rx;
        r_ry       <= n_ry;
        r_rad_x_sq <= n_rad_x_sq;
        r_rad_y_sq <= n_rad_y_sq;
        r_off_x    <= n_off_x;
        r_off_y    <= n_off_y;
        r_px       <= n_px;
        r_py       <= n_py;
        r_dec      <= n_dec;
        r_prod     <= n_prod;
        r_acc      <= n_acc;
        r_x_right  <= n_x_right;
        r_x_left   <= n_x_left;
        r_y_upper  <= n_y_upper;
        r_y_lower  <= n_y_lower;
        r_last     <= n_last;
        r_status   <= n_status;
    end

    assign o_sts.active     = r_active;
    assign o_sts.region_two = r_region_two;
    assign o_sts.px_lt_py   = (r_px < r_py);
    assign o_sts.out_free   = !r_out_valid || o_out.ready;

    assign o_out.valid      = r_out_valid;
    assign o_out.x_right    = r_x_right;
    assign o_out.x_left     = r_x_left;
    assign o_out.y_upper    = r_y_upper;
    assign o_out.y_lower    = r_y_lower;
    assign o_out.last_point = r_last;
    assign o_out.status     = r_status;

    `MES_ASSERT_NOW(a_step_has_y, (i_cmd.op == OP_STEP1) || (i_cmd.op == OP_STEP2), r_off_y != '0, "step taken on an ellipse whose y offset is already zero")
    `MES_ASSERT_NOW(a_last_ends_ellipse, r_out_valid && r_last && !r_status, !r_active, "ellipse still active while its last point waits")

endmodule

@@ rtl/midpoint_ellipse_stepper.sv @@
// Top level of the midpoint ellipse stepper.
//
// A start beat (func 0) loads a center and two semi-axes and returns the first point
// (x offset 0, y offset Ry); each next beat (func 1) returns the following point of
// the midpoint ellipse, mirrored to four quadrants, and the point with y offset zero
// is flagged last. A next beat with no ellipse running returns status 1. Every input
// beat gives exactly one result beat. Items are handled one at a time: a plain step
// is accepted, then updates; a start runs load, SQX, SQY, MT and INIT1, and the step
// that enters region two runs MA to MF and R2INIT before STEP2, since the single
// shared multiplier forms the squared radii and the initial decision terms one product
// per cycle. A finished point sits in an output register, so the next beat is accepted
// while it waits; the following point is held back only until that register is taken.
module midpoint_ellipse_stepper
    import mes_pkg::*;
#(
    parameter int RADIUS_BITS = RADIUS_BITS_DEF,
    parameter int COORD_BITS  = COORD_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mes_in_if.sink    i_in,
    mes_out_if.source o_out
);

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_ready;

    assign i_in.ready = w_ready;

    mes_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .i_func  (i_in.func),
        .i_sts   (w_sts),
        .o_ready (w_ready),
        .o_cmd   (w_cmd)
    );

    mes_dp #(
        .RADIUS_BITS (RADIUS_BITS),
        .COORD_BITS  (COORD_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_center_x (i_in.center_x),
        .i_center_y (i_in.center_y),
        .i_radius_x (i_in.radius_x),
        .i_radius_y (i_in.radius_y),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .o_out      (o_out)
    );

endmodule
